// ----- rtl/sat_pkg.sv -----
// Shared types, codes and field widths of the sorted array table.
`default_nettype none
package sat_pkg;

   localparam int KEY_W            = 32;
   localparam int MODE_W           = 2;
   localparam int IDX_W            = 4;
   localparam int STATUS_W         = 2;
   localparam int POS_W            = 4;
   localparam int CNT_W            = 5;
   localparam int CAPACITY_DEFAULT = 16;

   typedef logic signed [KEY_W-1:0] key_type;

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      key_type           key;
      logic [IDX_W-1:0]  index;
   } sat_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    binary_position;
      logic [POS_W-1:0]    last_match_position;
      logic [CNT_W-1:0]    entry_count;
   } sat_rsp_type;

   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } sat_cell_ctrl_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_SEARCH,
      S_APPLY,
      S_FINISH
   } sat_state_type;

endpackage
`default_nettype wire

// ----- rtl/sat_cell.sv -----
// One table cell: holds one key, compares it with the probe, shifts with its neighbors.
`default_nettype none
module sat_cell #(
   parameter int CAPACITY = sat_pkg::CAPACITY_DEFAULT,
   parameter int INDEX    = 0,
   localparam int CW      = $clog2(CAPACITY + 1)
) (
   input  wire logic                          clock,
   input  wire sat_pkg::sat_cell_ctrl_type    ctrl,
   input  wire sat_pkg::key_type              key,
   input  wire logic [CW-1:0]                 count,
   input  wire logic [CW-1:0]                 ins_pos,
   input  wire logic [sat_pkg::IDX_W-1:0]     rem_idx,
   input  wire sat_pkg::key_type              prev_entry,
   input  wire sat_pkg::key_type              next_entry,
   output sat_pkg::key_type                   entry,
   output logic                               le,
   output logic                               eq
);
   import sat_pkg::*;

   key_type entry_ff, entry_in;
   logic    le_ff, le_in, eq_ff, eq_in;
   logic    in_use;

   always_comb begin
      in_use   = 32'(INDEX) < 32'(count);
      entry_in = entry_ff;
      le_in    = le_ff;
      eq_in    = eq_ff;
      if (ctrl.compare) begin
         le_in = in_use && !(key < entry_ff);
         eq_in = in_use && (key == entry_ff);
      end
      // open a gap at the insert point, or close the one left by a removal
      if (ctrl.insert) begin
         if (32'(INDEX) == 32'(ins_pos)) begin
            entry_in = key;
         end else if (32'(INDEX) > 32'(ins_pos)) begin
            entry_in = prev_entry;
         end
      end else if (ctrl.remove) begin
         if (32'(INDEX) >= 32'(rem_idx)) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      le_ff    <= le_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign le    = le_ff;
   assign eq    = eq_ff;

endmodule
`default_nettype wire

// ----- rtl/sat_search.sv -----
// Binary search stepper over the registered cell compare vectors.
`default_nettype none
module sat_search #(
   parameter int CAPACITY = sat_pkg::CAPACITY_DEFAULT,
   localparam int CW      = $clog2(CAPACITY + 1),
   localparam int AW      = $clog2(CAPACITY)
) (
   input  wire logic                clock,
   input  wire logic                start,
   input  wire logic [CW-1:0]       count,
   input  wire logic [CAPACITY-1:0] le_vec,
   input  wire logic [CAPACITY-1:0] eq_vec,
   output logic                     done,
   output logic                     hit,
   output logic [AW-1:0]            hit_pos,
   output logic [CW-1:0]            upper
);
   import sat_pkg::*;

   logic signed [CW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]      ub_lo_ff, ub_lo_in, ub_hi_ff, ub_hi_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_pos_ff, hit_pos_in;
   logic               a_run, b_run;
   logic [CW+1:0]      a_sum;
   logic [AW-1:0]      a_mid;
   logic [CW:0]        a_mid_ext;
   logic [CW:0]        b_sum;
   logic [AW-1:0]      b_mid;

   always_comb begin
      // floor-midpoint search that stops on the first hit
      a_run     = !hit_ff && (lo_ff <= hi_ff);
      a_sum     = (CW+2)'(lo_ff) + (CW+2)'(hi_ff);
      a_mid     = a_sum[AW:1];
      a_mid_ext = (CW+1)'(a_mid);
      // upper bound: count of valid keys less than or equal to the probe
      b_run     = ub_lo_ff < ub_hi_ff;
      b_sum     = (CW+1)'(ub_lo_ff) + (CW+1)'(ub_hi_ff);
      b_mid     = b_sum[AW:1];

      lo_in      = lo_ff;
      hi_in      = hi_ff;
      hit_in     = hit_ff;
      hit_pos_in = hit_pos_ff;
      ub_lo_in   = ub_lo_ff;
      ub_hi_in   = ub_hi_ff;

      if (start) begin
         lo_in    = '0;
         hi_in    = $signed((CW+1)'(count) - (CW+1)'(1));
         hit_in   = 1'b0;
         ub_lo_in = '0;
         ub_hi_in = count;
      end else begin
         if (a_run) begin
            if (eq_vec[a_mid]) begin
               hit_in     = 1'b1;
               hit_pos_in = a_mid;
            end else if (le_vec[a_mid]) begin
               lo_in = $signed(a_mid_ext + (CW+1)'(1));
            end else begin
               hi_in = $signed(a_mid_ext - (CW+1)'(1));
            end
         end
         if (b_run) begin
            if (le_vec[b_mid]) begin
               ub_lo_in = CW'(b_mid) + CW'(1);
            end else begin
               ub_hi_in = CW'(b_mid);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      hit_ff     <= hit_in;
      hit_pos_ff <= hit_pos_in;
      ub_lo_ff   <= ub_lo_in;
      ub_hi_ff   <= ub_hi_in;
   end

   assign done    = !a_run && !b_run;
   assign hit     = hit_ff;
   assign hit_pos = hit_pos_ff;
   assign upper   = ub_lo_ff;

endmodule
`default_nettype wire

// ----- rtl/sorted_array_table.sv -----
// Top level of the sorted array table: cell row, search stepper, sequencer, result register.
//
// Keeps up to CAPACITY signed 32-bit keys in ascending order in a row of
// cells, one key per cell. A request beat carries a mode (insert, search,
// remove at index), a key and an index; each request gives exactly one
// response beat with a status, the insert or binary-search position, the
// last index holding a searched key, and the entry count after the
// operation. One operation at a time: a request passes the compare
// state, the binary-search steps, a shift state if it changes the table,
// and the finish state. The search stepper walks the floor-midpoint
// search and the upper-bound search side by side, one probe of each per
// cycle, over the compare flags that every cell registers at once. A new
// request is taken while the previous response still waits in the output
// register. Entries at or above the count hold no defined value and are
// never reported.
`default_nettype none
module sorted_array_table #(
   parameter int CAPACITY = sat_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sat_pkg::sat_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sat_pkg::sat_rsp_type      rsp_data
);
   import sat_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   // sequencer state and per-request registers
   sat_state_type state_ff, state_in;
   sat_req_type   req_ff, req_in;
   logic          ins_ok_ff, ins_ok_in;
   logic          rem_ok_ff, rem_ok_in;
   logic [CW-1:0] count_ff, count_in;
   sat_rsp_type   rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // cell row
   sat_cell_ctrl_type cell_ctrl;
   key_type           entry_w [CAPACITY];
   logic [CAPACITY-1:0] le_vec, eq_vec;

   // search stepper
   logic          search_start;
   logic          search_done;
   logic          search_hit;
   logic [AW-1:0] search_hit_pos;
   logic [CW-1:0] search_upper;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      key_type prev_w, next_w;
      if (i == 0) begin : g_first
         assign prev_w = entry_w[i];
      end else begin : g_prev
         assign prev_w = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_w = entry_w[i];
      end else begin : g_next
         assign next_w = entry_w[i+1];
      end
      sat_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .key        (req_ff.key),
         .count      (count_ff),
         .ins_pos    (search_upper),
         .rem_idx    (req_ff.index),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .entry      (entry_w[i]),
         .le         (le_vec[i]),
         .eq         (eq_vec[i])
      );
   end

   sat_search #(
      .CAPACITY (CAPACITY)
   ) u_search (
      .clock   (clock),
      .start   (search_start),
      .count   (count_ff),
      .le_vec  (le_vec),
      .eq_vec  (eq_vec),
      .done    (search_done),
      .hit     (search_hit),
      .hit_pos (search_hit_pos),
      .upper   (search_upper)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      ins_ok_ff <= ins_ok_in;
      rem_ok_ff <= rem_ok_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ins_ok_in    = ins_ok_ff;
      rem_ok_in    = rem_ok_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      // drop the response once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      search_start = 1'b0;
      cell_ctrl    = '0;

      case (state_ff)
         S_IDLE: begin
            // hold off requests while reset is applied
            req_ready = !reset;
            if (req_valid && req_ready) begin
               // capture the beat and judge room and index against the current count
               req_in    = req_data;
               ins_ok_in = count_ff < CW'(CAPACITY);
               rem_ok_in = 32'(req_data.index) < 32'(count_ff);
               state_in  = S_COMPARE;
            end
         end
         S_COMPARE: begin
            // every cell compares its key with the probe in the same cycle
            cell_ctrl.compare = 1'b1;
            search_start      = 1'b1;
            state_in          = S_SEARCH;
         end
         S_SEARCH: begin
            if (search_done) begin
               if ((req_ff.mode == MODE_INSERT && ins_ok_ff) ||
                   (req_ff.mode == MODE_REMOVE && rem_ok_ff)) begin
                  state_in = S_APPLY;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_APPLY: begin
            // shift the row by one place and adjust the count
            if (req_ff.mode == MODE_INSERT) begin
               cell_ctrl.insert = 1'b1;
               count_in         = count_ff + CW'(1);
            end else begin
               cell_ctrl.remove = 1'b1;
               count_in         = count_ff - CW'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status              = ST_OK;
               rsp_in.binary_position     = '0;
               rsp_in.last_match_position = '0;
               rsp_in.entry_count         = CNT_W'(32'(count_ff));
               case (req_ff.mode)
                  MODE_INSERT: begin
                     if (ins_ok_ff) begin
                        rsp_in.binary_position = POS_W'(32'(search_upper));
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                  end
                  MODE_SEARCH: begin
                     if (search_hit) begin
                        rsp_in.binary_position     = POS_W'(32'(search_hit_pos));
                        rsp_in.last_match_position =
                           POS_W'(32'(search_upper - CW'(1)));
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                     end
                  end
                  MODE_REMOVE: begin
                     if (!rem_ok_ff) begin
                        rsp_in.status = ST_BAD_INDEX;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_OK;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the count moves only while the row shifts
   a_count_only_in_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_APPLY) |=> $stable(count_ff))
      else $error("entry count changed outside the shift cycle");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && req_ff.mode == MODE_INSERT) |=>
         (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the count by one");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> (count_ff <= CW'(CAPACITY)))
      else $error("entry count above capacity");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finish state");

endmodule
`default_nettype wire
